@@ src/i2a_pkg.sv @@
// Shared types, format codes and character constants for the integer to ASCII converter.
package i2a_pkg;

  localparam int MAG_W     = 32;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = 4 * DIGITS;
  localparam int DD_STAGES = 4;
  localparam int DD_STEPS  = MAG_W / DD_STAGES;
  localparam int IDX_W     = 4;

  localparam logic [3:0] FUNC_U32_DEC = 4'd0;
  localparam logic [3:0] FUNC_S32_DEC = 4'd1;
  localparam logic [3:0] FUNC_U16_DEC = 4'd2;
  localparam logic [3:0] FUNC_S16_DEC = 4'd3;
  localparam logic [3:0] FUNC_U8_DEC  = 4'd4;
  localparam logic [3:0] FUNC_S8_DEC  = 4'd5;
  localparam logic [3:0] FUNC_U32_HEX = 4'd6;
  localparam logic [3:0] FUNC_U16_HEX = 4'd7;
  localparam logic [3:0] FUNC_U8_HEX  = 4'd8;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;

  typedef struct packed {
    logic               hex;
    logic               neg;
    logic [IDX_W-1:0]   top;
    logic [MAG_W-1:0]   mag;
    logic [BCD_W-1:0]   bcd;
  } item_t;

  function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic hex);
    logic [6:0] ch;
    if (hex && (nib >= 4'd10)) begin
      ch = CH_A + {3'b000, nib} - 7'd10;
    end else begin
      ch = CH_ZERO + {3'b000, nib};
    end
    return ch;
  endfunction

endpackage

@@ src/i2a_decode.sv @@
// Entry stage: decode the format, mask the value and form the magnitude and sign.
module i2a_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              accept,
  input  logic [3:0]        func,
  input  logic [31:0]       value,
  output logic              vld_r,
  output i2a_pkg::item_t    item_r
);

  logic                      ok;
  logic                      is_hex;
  logic                      is_signed;
  logic [1:0]                wsel;
  logic [i2a_pkg::IDX_W-1:0] hex_top;
  logic [31:0]               x;
  logic                      sign;
  logic                      neg;
  i2a_pkg::item_t            item_nxt;

  always_comb begin
    ok        = 1'b1;
    is_hex    = 1'b0;
    is_signed = 1'b0;
    wsel      = 2'd2;
    hex_top   = '0;
    unique case (func)
      i2a_pkg::FUNC_U32_DEC: wsel = 2'd2;
      i2a_pkg::FUNC_S32_DEC: begin wsel = 2'd2; is_signed = 1'b1; end
      i2a_pkg::FUNC_U16_DEC: wsel = 2'd1;
      i2a_pkg::FUNC_S16_DEC: begin wsel = 2'd1; is_signed = 1'b1; end
      i2a_pkg::FUNC_U8_DEC:  wsel = 2'd0;
      i2a_pkg::FUNC_S8_DEC:  begin wsel = 2'd0; is_signed = 1'b1; end
      i2a_pkg::FUNC_U32_HEX: begin wsel = 2'd2; is_hex = 1'b1; hex_top = 4'd7; end
      i2a_pkg::FUNC_U16_HEX: begin wsel = 2'd1; is_hex = 1'b1; hex_top = 4'd3; end
      i2a_pkg::FUNC_U8_HEX:  begin wsel = 2'd0; is_hex = 1'b1; hex_top = 4'd1; end
      default:               ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (wsel)
      2'd0: begin x = {24'd0, value[7:0]};  sign = value[7];  end
      2'd1: begin x = {16'd0, value[15:0]}; sign = value[15]; end
      default: begin x = value;             sign = value[31]; end
    endcase
    neg = is_signed && sign && !is_hex;

    item_nxt.hex = is_hex;
    item_nxt.neg = neg;
    item_nxt.top = hex_top;
    if (is_hex) begin
      // hex digits go straight into the digit field; dabble stages pass them through
      item_nxt.mag = '0;
      item_nxt.bcd = {8'd0, x};
    end else begin
      item_nxt.bcd = '0;
      unique case (wsel)
        2'd0:    item_nxt.mag = neg ? {24'd0, 8'(~x[7:0] + 8'd1)}   : x;
        2'd1:    item_nxt.mag = neg ? {16'd0, 16'(~x[15:0] + 16'd1)} : x;
        default: item_nxt.mag = neg ? (~x + 32'd1) : x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= accept && ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ src/i2a_dabble.sv @@
// One double dabble pipeline stage: a fixed slice of shift-and-add-3 steps.
module i2a_dabble (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  i2a_pkg::item_t    in_item,
  output logic              vld_r,
  output i2a_pkg::item_t    item_r
);

  i2a_pkg::item_t item_nxt;

  always_comb begin
    logic [i2a_pkg::BCD_W-1:0] bcd;
    logic [i2a_pkg::MAG_W-1:0] mag;
    bcd = in_item.bcd;
    mag = in_item.mag;
    item_nxt = in_item;
    if (!in_item.hex) begin
      for (int s = 0; s < i2a_pkg::DD_STEPS; s++) begin
        for (int d = 0; d < i2a_pkg::DIGITS; d++) begin
          if (bcd[4*d +: 4] >= 4'd5) begin
            bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
          end
        end
        bcd = {bcd[i2a_pkg::BCD_W-2:0], mag[i2a_pkg::MAG_W-1]};
        mag = {mag[i2a_pkg::MAG_W-2:0], 1'b0};
      end
      item_nxt.bcd = bcd;
      item_nxt.mag = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ src/i2a_serial.sv @@
// Character serializer: sign, leading zero suppression and one character per cycle out.
module i2a_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  i2a_pkg::item_t    in_item,
  output logic              free,
  output logic              out_valid,
  output logic [6:0]        out_char_code,
  output logic              out_last_char
);

  logic                      ser_vld_r;
  logic                      neg_r;
  logic                      hex_r;
  logic [i2a_pkg::IDX_W-1:0] idx_r;
  logic [i2a_pkg::BCD_W-1:0] bcd_r;
  logic                      out_valid_r;
  logic [6:0]                out_char_r;
  logic                      out_last_r;

  logic [i2a_pkg::IDX_W-1:0] top_dec;
  logic [i2a_pkg::IDX_W-1:0] start_idx;
  logic [i2a_pkg::BCD_W-1:0] bcd_sh;
  logic [3:0]                cur_nib;
  logic                      emit_last;

  // highest nonzero decimal digit; zero prints a single digit
  always_comb begin
    top_dec = '0;
    for (int d = 0; d < i2a_pkg::DIGITS; d++) begin
      if (in_item.bcd[4*d +: 4] != 4'd0) begin
        top_dec = i2a_pkg::IDX_W'(d);
      end
    end
    start_idx = in_item.hex ? in_item.top : top_dec;
  end

  assign bcd_sh    = bcd_r >> {idx_r, 2'b00};
  assign cur_nib   = bcd_sh[3:0];
  assign emit_last = ser_vld_r && !neg_r && (idx_r == '0);
  assign free      = !ser_vld_r || emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ser_vld_r;
      if (free) begin
        ser_vld_r <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= neg_r ? i2a_pkg::CH_MINUS : i2a_pkg::digit_char(cur_nib, hex_r);
    out_last_r <= emit_last;
    if (free) begin
      neg_r <= in_item.neg;
      hex_r <= in_item.hex;
      idx_r <= start_idx;
      bcd_r <= in_item.bcd;
    end else if (neg_r) begin
      neg_r <= 1'b0;
    end else begin
      idx_r <= idx_r - i2a_pkg::IDX_W'(1);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

@@ src/integer_to_ascii_converter.sv @@
// Top level of the integer to ASCII converter: pipeline wiring, flow control and checks.
//
// Usage:
//   Input: drive in_func and in_value and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. Format codes 9 to 15 are taken
//   and dropped without output.
//   Output: each character appears for exactly one cycle with out_valid high;
//   out_last_char marks the final character of a number. The receiver cannot stall,
//   so the block never holds a character back once it is shown.
//   Pipeline: one decode stage, four double dabble stages of eight shift-and-add-3
//   steps each, then a serializer and an output register.
//   Flow: a number is sent as its characters, 1 to 11 of them, through the
//   single-character output port; the serializer loads the next number
//   in the cycle its last character is sent, so runs follow with no gap. A new
//   transaction may be taken every cycle while stages are empty; busy rises only
//   when every stage holds a number waiting on the serializer.
//   Reset: synchronous, active low; clears all valid bits, drops numbers in flight.
module integer_to_ascii_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [6:0]  out_char_code,
  output logic        out_last_char
);

  localparam int NS = i2a_pkg::DD_STAGES;

  logic [NS:0]    vld;
  logic [NS:0]    en;
  i2a_pkg::item_t item [NS+1];
  logic           ser_free;
  logic           accept;

  // each stage advances when it is empty or its successor advances
  always_comb begin
    en[NS] = !vld[NS] || ser_free;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign busy   = !en[0];
  assign accept = start && en[0];

  i2a_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[0]),
    .accept (accept),
    .func   (in_func),
    .value  (in_value),
    .vld_r  (vld[0]),
    .item_r (item[0])
  );

  // shift-and-add-3 slices; hex numbers pass through untouched
  for (genvar g = 0; g < NS; g++) begin : g_dd
    i2a_dabble u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[g+1]),
      .in_vld  (vld[g]),
      .in_item (item[g]),
      .vld_r   (vld[g+1]),
      .item_r  (item[g+1])
    );
  end

  i2a_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (vld[NS]),
    .in_item       (item[NS]),
    .free          (ser_free),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // the last-character flag only travels with a shown character
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_char |-> out_valid)
    else $error("last character flag without valid");

  // a run of characters is never broken before its last character
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_char) |=> out_valid)
    else $error("character run broken");

  // busy only while the serializer is mid-run, so a non-final character follows
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !out_last_char))
    else $error("busy without a run in progress");

endmodule

@@ verif/integer_to_ascii_converter_tb.sv @@
// Self-checking testbench for integer_to_ascii_converter: directed table, then random numbers.
`timescale 1ns / 100ps

module integer_to_ascii_converter_tb;

  // Format codes 9 to 15 carry no meaning; the block takes and drops them.
  localparam logic [3:0] FUNC_RSVD_FIRST = 4'd9;
  localparam logic [3:0] FUNC_RSVD_LAST  = 4'd15;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 370;
  // Drain wait: longer than the time to the first character plus the longest run.
  localparam int DRAIN_CYCLES = 24;
  // Watchdog budget: ~400 numbers, each with up to 11 characters, the longest idle gap and pipeline fill, with margin.
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } ascii_char_t;

  // One row of the directed table: text is the typed-in answer, used when known is set.
  typedef struct {
    logic [3:0]  func;
    logic [31:0] value;
    bit          known;
    string       text;
  } number_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_func;
  logic [31:0] in_value;
  logic        out_valid;
  logic [6:0]  out_char_code;
  logic        out_last_char;

  ascii_char_t pending_chars[$];
  int          mismatches;
  int          cycle_count;
  int          burst_left;

  integer_to_ascii_converter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Append one character to the expected text stream.
  function automatic void expect_char(input logic [6:0] code, input logic last);
    ascii_char_t c;
    c.code = code;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Queue a typed-in answer; the final character carries the last flag.
  function automatic void expect_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      expect_char(7'(text[i]), i == text.len() - 1);
    end
  endfunction

  // Work out the characters a number prints as and queue them in order.
  function automatic void spell_number(input logic [3:0] func, input logic [31:0] value);
    int unsigned width;
    int unsigned hex_digits;
    bit          as_hex;
    bit          as_signed;
    bit          started;
    logic [31:0] mask;
    logic [31:0] raw;
    logic [31:0] mag;
    logic [39:0] bcd;
    logic [3:0]  nib;
    width      = 32;
    hex_digits = 0;
    as_hex     = 1'b0;
    as_signed  = 1'b0;
    case (func)
      i2a_pkg::FUNC_U32_DEC: width = 32;
      i2a_pkg::FUNC_S32_DEC: begin
        width     = 32;
        as_signed = 1'b1;
      end
      i2a_pkg::FUNC_U16_DEC: width = 16;
      i2a_pkg::FUNC_S16_DEC: begin
        width     = 16;
        as_signed = 1'b1;
      end
      i2a_pkg::FUNC_U8_DEC: width = 8;
      i2a_pkg::FUNC_S8_DEC: begin
        width     = 8;
        as_signed = 1'b1;
      end
      i2a_pkg::FUNC_U32_HEX: begin
        as_hex     = 1'b1;
        hex_digits = 8;
      end
      i2a_pkg::FUNC_U16_HEX: begin
        as_hex     = 1'b1;
        hex_digits = 4;
      end
      i2a_pkg::FUNC_U8_HEX: begin
        as_hex     = 1'b1;
        hex_digits = 2;
      end
      default: return;  // unused code: no text at all
    endcase

    if (as_hex) begin
      // Every nibble prints, most significant first, no suppression.
      for (int d = hex_digits; d > 0; d--) begin
        nib = value[4*(d-1) +: 4];
        expect_char((nib < 4'd10) ? i2a_pkg::CH_ZERO + 7'(nib)
                                  : i2a_pkg::CH_A + 7'(nib) - 7'd10, d == 1);
      end
      return;
    end

    mask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    raw  = value & mask;
    mag  = raw;
    // Negate inside the width; the most negative value wraps to its own magnitude.
    if (as_signed && raw[width-1]) begin
      mag = (~raw + 32'd1) & mask;
      expect_char(i2a_pkg::CH_MINUS, 1'b0);
    end

    // Shift-and-add-3 over all 32 bits into ten BCD digits.
    bcd = '0;
    for (int i = 0; i < 32; i++) begin
      for (int d = 0; d < 10; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
      bcd = {bcd[38:0], mag[31-i]};
    end

    // Drop leading zeros, but the units digit always prints.
    started = 1'b0;
    for (int d = 9; d >= 0; d--) begin
      nib = bcd[4*d +: 4];
      if (nib != 4'd0) started = 1'b1;
      if (started || d == 0) expect_char(i2a_pkg::CH_ZERO + 7'(nib), d == 0);
    end
  endfunction

  // Present one number, hold it until the block takes it, then idle for a random gap.
  // start is never lowered and raised in the same step: a zero gap leaves it high.
  task automatic send_number(input logic [3:0] func, input logic [31:0] value,
                             input bit known, input string text);
    int gap;
    int roll;
    in_func  <= func;
    in_value <= value;
    start    <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // Transaction taken at this edge: record what it must print.
    if (known) expect_text(text);
    else spell_number(func, value);

    // Back-to-back bursts push the serializer until busy rises; otherwise mostly short gaps.
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 30);
      roll = $urandom_range(0, 99);
      if (roll < 45) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Compare every strobed character against the oldest pending one.
  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_chars.size() == 0) begin
        $error("out_char_code: expected nothing, got %h (last %b)", out_char_code,
               out_last_char);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("out_char_code: expected %h, got %h", want.code, out_char_code);
          mismatches++;
        end
        if (out_last_char !== want.last) begin
          $error("out_last_char: expected %b, got %b", want.last, out_last_char);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost character ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_to_ascii_converter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    number_row_t rows[$];
    logic [3:0]  func;
    logic [31:0] value;
    logic [31:0] mask;
    int          sent;

    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_func  <= i2a_pkg::FUNC_U32_DEC;
    in_value <= '0;

    // Directed numbers: width extremes, most negative values, zero, every format and the
    // unused codes. Rows with known clear go through the predictor.
    rows = '{
      '{i2a_pkg::FUNC_U32_DEC, 32'h0000_0000, 1'b1, "0"},
      '{i2a_pkg::FUNC_U32_DEC, 32'hFFFF_FFFF, 1'b1, "4294967295"},
      '{i2a_pkg::FUNC_S32_DEC, 32'h8000_0000, 1'b1, "-2147483648"},
      '{i2a_pkg::FUNC_S32_DEC, 32'h7FFF_FFFF, 1'b1, "2147483647"},
      '{i2a_pkg::FUNC_S32_DEC, 32'hFFFF_FFFF, 1'b1, "-1"},
      '{i2a_pkg::FUNC_U16_DEC, 32'h1234_FFFF, 1'b1, "65535"},
      '{i2a_pkg::FUNC_S16_DEC, 32'hABCD_8000, 1'b1, "-32768"},
      '{i2a_pkg::FUNC_S16_DEC, 32'h0000_7FFF, 1'b1, "32767"},
      '{i2a_pkg::FUNC_S16_DEC, 32'h0000_FFFF, 1'b1, "-1"},
      '{i2a_pkg::FUNC_U8_DEC,  32'hFFFF_FF00, 1'b1, "0"},
      '{i2a_pkg::FUNC_U8_DEC,  32'h0000_00FF, 1'b1, "255"},
      '{i2a_pkg::FUNC_S8_DEC,  32'h0000_0080, 1'b1, "-128"},
      '{i2a_pkg::FUNC_S8_DEC,  32'hFFFF_FF7F, 1'b1, "127"},
      '{i2a_pkg::FUNC_U32_HEX, 32'hFFFF_FFFF, 1'b1, "FFFFFFFF"},
      '{i2a_pkg::FUNC_U32_HEX, 32'h0000_0000, 1'b1, "00000000"},
      '{i2a_pkg::FUNC_U16_HEX, 32'hDEAD_BEEF, 1'b1, "BEEF"},
      '{i2a_pkg::FUNC_U16_HEX, 32'h0000_A5C3, 1'b1, "A5C3"},
      '{i2a_pkg::FUNC_U8_HEX,  32'h1234_569A, 1'b1, "9A"},
      '{FUNC_RSVD_FIRST,       32'hFFFF_FFFF, 1'b1, ""},
      '{FUNC_RSVD_LAST,        32'h1234_5678, 1'b1, ""},
      '{i2a_pkg::FUNC_U32_DEC, 32'h3B9A_CA00, 1'b1, "1000000000"},
      '{i2a_pkg::FUNC_U32_DEC, 32'h1234_5678, 1'b0, ""},
      '{i2a_pkg::FUNC_S32_DEC, 32'hC000_0001, 1'b0, ""},
      '{i2a_pkg::FUNC_S8_DEC,  32'hFFFF_FF85, 1'b0, ""},
      '{i2a_pkg::FUNC_U16_DEC, 32'h0000_0009, 1'b1, "9"}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_number(rows[i].func, rows[i].value, rows[i].known, rows[i].text);

    // Random numbers. Unused codes are sprinkled in but do not count toward the total.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        func = 4'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
      end else begin
        func = 4'($urandom_range(i2a_pkg::FUNC_U32_DEC, i2a_pkg::FUNC_U8_HEX));
      end

      case (func)
        i2a_pkg::FUNC_U16_DEC, i2a_pkg::FUNC_S16_DEC, i2a_pkg::FUNC_U16_HEX:
          mask = 32'h0000_FFFF;
        i2a_pkg::FUNC_U8_DEC, i2a_pkg::FUNC_S8_DEC, i2a_pkg::FUNC_U8_HEX:
          mask = 32'h0000_00FF;
        default:
          mask = 32'hFFFF_FFFF;
      endcase

      // Bits above the chosen width stay random so they must be ignored.
      value = $urandom;
      case ($urandom_range(0, 3))
        0: ;  // full-width random bits
        1: begin
          // Shorten the number so every digit count shows up.
          value = (value & ~mask) | (($urandom & mask) >> $urandom_range(0, 31));
        end
        2: begin
          // Small negative numbers: a short magnitude negated within the width.
          value = (value & ~mask) |
                  ((~(($urandom & mask) >> $urandom_range(0, 31)) + 32'd1) & mask);
        end
        default: begin
          // Edges: top of range, wrap to zero, and around the sign boundary.
          value = (value & ~mask) |
                  (((mask >> $urandom_range(0, 1)) + 32'($urandom_range(0, 2)) - 32'd1) & mask);
        end
      endcase

      send_number(func, value, 1'b0, "");
      if (func <= i2a_pkg::FUNC_U8_HEX) sent++;
    end
    start <= 1'b0;

    // Drain: every expected character in, then a quiet stretch to catch strays.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("integer_to_ascii_converter_tb: PASS");
    end else begin
      $display("integer_to_ascii_converter_tb: FAIL");
    end
    $finish;
  end

endmodule
